### src/i2c_clm_pkg.sv
package i2c_clm_pkg;

  localparam int unsigned FifoDepth   = 32;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);
  localparam int unsigned MaxCommands = 16;
  localparam int unsigned RegWords    = 64;
  localparam int unsigned RegAw       = $clog2(RegWords);

  localparam logic [7:0]  CmdBase  = 8'h58;
  localparam logic [31:0] DoneBit  = 32'h8000_0000;

  localparam logic [7:0] OffCtrl   = 8'h04;
  localparam logic [7:0] OffStatus = 8'h08;
  localparam logic [7:0] OffFifoCf = 8'h18;
  localparam logic [7:0] OffData   = 8'h1C;
  localparam logic [7:0] OffRawIrq = 8'h20;
  localparam logic [7:0] OffIrqClr = 8'h24;
  localparam logic [7:0] OffIrqEn  = 8'h28;
  localparam logic [7:0] OffIrqSt  = 8'h2C;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActRead  = 2'd1;
  localparam logic [1:0] ActEvent = 2'd2;

  localparam logic [2:0] EvStart = 3'd0;
  localparam logic [2:0] EvAck   = 3'd1;
  localparam logic [2:0] EvNack  = 3'd2;
  localparam logic [2:0] EvByte  = 3'd3;
  localparam logic [2:0] EvIdle  = 3'd4;

  localparam logic [2:0] OpNone  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpWrite = 3'd2;
  localparam logic [2:0] OpRead  = 3'd3;
  localparam logic [2:0] OpStop  = 3'd4;

  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdEnd   = 3'd4;

  localparam logic [4:0] IrqRxOvf  = 5'd2;
  localparam logic [4:0] IrqEnd    = 5'd3;
  localparam logic [4:0] IrqTxEmp  = 5'd6;
  localparam logic [4:0] IrqFail   = 5'd7;
  localparam logic [4:0] IrqNack   = 5'd10;
  localparam logic [4:0] IrqTxOvf  = 5'd11;
  localparam logic [4:0] IrqRxUnf  = 5'd12;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  reg_offset;
    logic [31:0] write_value;
    logic [2:0]  bus_event;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic [2:0]  bus_op;
    logic [7:0]  bus_byte;
    logic        bus_is_address;
    logic        bus_dir_write;
    logic        read_send_ack;
    logic        busy_res;
  } out_item_t;

endpackage

### src/i2c_command_list_master_core.sv
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out       out  out_valid_o / out_stall_i out_data_o (out_item_t)
// cfg       in   cfg_valid_i / cfg_ready_o cfg_data_i (variant bit)
//
// one item at a time: a register write that starts no transaction goes
// straight to the output state and a read passes through a register-read
// state; a transaction start or a bus event walks the command slots, skipping
// each zero-length slot, the register file being read in the state before each use
// reset clears control state and register valid bits; fifos start empty
// a stalled result holds the sequencer in its output state
module i2c_command_list_master_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  i2c_clm_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output i2c_clm_pkg::out_item_t out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);
  import i2c_clm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REG_RD, S_CD_RD, S_CD_WR, S_RUN_RD, S_RUN_EX, S_FIN_RD, S_FIN_WR,
    S_ACK_RD, S_ACK_EX, S_TX_RD, S_TX_EX, S_OUT
  } state_e;

  typedef enum logic [1:0] {AD_RUN, AD_FIN_FAIL, AD_FIN_END} after_e;

  state_e              state_q;
  after_e              after_q;
  logic                variant_q;
  logic [FifoAw-1:0]   tx_head_q, rx_head_q;
  logic [FifoAw:0]     tx_cnt_q, rx_cnt_q;
  logic [31:0]         raw_q, en_q;
  logic [4:0]          idx_q;
  logic [7:0]          bytes_q;
  logic                busy_q, busbusy_q, expaddr_q, ackchk_q, write_q;
  logic [4:0]          fin_bit_q;
  logic                fin_rel_q;
  logic [7:0]          off_q;
  out_item_t           res_q, out_q;
  out_item_t           res_fin;
  logic                out_vld_q;

  logic [31:0]         rf_mem [RegWords];
  logic [RegWords-1:0] rf_vld_q;
  logic [31:0]         rf_rdata_q;
  logic                rf_rvld_q;
  logic [31:0]         rf_word;
  logic                rf_re, rf_we;
  logic [RegAw-1:0]    rf_raddr, rf_waddr;
  logic [31:0]         rf_wdata;

  logic [7:0]          tx_mem [FifoDepth];
  logic [7:0]          rx_mem [FifoDepth];
  logic [7:0]          tx_rdata_q, rx_rdata_q;
  logic                tx_we, rx_we;

  logic                in_acc;
  logic                ctrl_start;
  logic [RegAw-1:0]    slot_addr;
  logic [4:0]          slots;
  logic [2:0]          opc, op_rs, op_rd, op_sp;
  logic [7:0]          bytes_dec;
  logic                tx_full, rx_full;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign ctrl_start = (in_data_i.reg_offset == OffCtrl) && in_data_i.write_value[5] &&
                      !busy_q && in_data_i.write_value[4];

  assign rf_word   = rf_rvld_q ? rf_rdata_q : 32'd0;
  assign slot_addr = RegAw'(CmdBase[7:2]) + RegAw'(idx_q);
  assign slots     = variant_q ? 5'd8 : 5'(MaxCommands);
  assign opc       = rf_word[13:11];
  assign op_rs     = variant_q ? 3'd6 : 3'd0;
  assign op_rd     = variant_q ? 3'd3 : 3'd2;
  assign op_sp     = variant_q ? 3'd2 : 3'd3;
  assign bytes_dec = bytes_q - 8'd1;
  assign tx_full   = (tx_cnt_q == (FifoAw+1)'(FifoDepth));
  assign rx_full   = (rx_cnt_q == (FifoAw+1)'(FifoDepth));

  always_comb begin
    res_fin          = res_q;
    res_fin.irq      = |(raw_q & en_q);
    res_fin.busy_res = busy_q;
  end

  // register file port control
  always_comb begin
    rf_re    = 1'b0;
    rf_raddr = slot_addr;
    rf_we    = 1'b0;
    rf_waddr = slot_addr;
    rf_wdata = rf_word | DoneBit;
    unique case (state_q)
      S_IDLE: begin
        rf_re    = in_acc;
        rf_raddr = in_data_i.reg_offset[7:2];
        rf_we    = in_acc && (in_data_i.action == ActWrite);
        rf_waddr = in_data_i.reg_offset[7:2];
        rf_wdata = in_data_i.write_value;
      end
      S_CD_RD, S_RUN_RD, S_ACK_RD: rf_re = 1'b1;
      S_FIN_RD: begin
        rf_re    = 1'b1;
        rf_raddr = RegAw'(OffCtrl[7:2]);
      end
      S_CD_WR: rf_we = 1'b1;
      S_FIN_WR: begin
        rf_we    = 1'b1;
        rf_waddr = RegAw'(OffCtrl[7:2]);
        rf_wdata = rf_word & ~(32'd1 << 5);
      end
      default: ;
    endcase
  end

  assign tx_we = (state_q == S_IDLE) && in_acc && (in_data_i.action == ActWrite) &&
                 (in_data_i.reg_offset == OffData) && !tx_full;
  assign rx_we = (state_q == S_IDLE) && in_acc && (in_data_i.action == ActEvent) &&
                 busy_q && (in_data_i.bus_event == EvByte) && !rx_full;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (rf_re) begin
      rf_rdata_q <= rf_mem[rf_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q  <= '0;
      rf_rvld_q <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (rf_re) begin
        rf_rvld_q <= rf_vld_q[rf_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_head_q + FifoAw'(tx_cnt_q)] <= in_data_i.write_value[7:0];
    end
    if (state_q == S_TX_RD) begin
      tx_rdata_q <= tx_mem[tx_head_q];
    end
    if (rx_we) begin
      rx_mem[rx_head_q + FifoAw'(rx_cnt_q)] <= in_data_i.rx_byte;
    end
    if (state_q == S_IDLE) begin
      rx_rdata_q <= rx_mem[rx_head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      after_q   <= AD_RUN;
      variant_q <= 1'b0;
      tx_head_q <= '0;
      tx_cnt_q  <= '0;
      rx_head_q <= '0;
      rx_cnt_q  <= '0;
      raw_q     <= '0;
      en_q      <= '0;
      idx_q     <= '0;
      bytes_q   <= '0;
      busy_q    <= 1'b0;
      busbusy_q <= 1'b0;
      expaddr_q <= 1'b0;
      ackchk_q  <= 1'b0;
      write_q   <= 1'b0;
      fin_bit_q <= '0;
      fin_rel_q <= 1'b0;
      off_q     <= '0;
      res_q     <= '0;
      out_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        variant_q <= cfg_data_i;
      end
      if (out_vld_q && !out_stall_i && (state_q != S_OUT)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_q <= '0;
            off_q <= in_data_i.reg_offset;
            unique case (in_data_i.action)
              ActWrite: begin
                state_q <= ctrl_start ? S_RUN_RD : S_OUT;
                unique case (in_data_i.reg_offset)
                  OffCtrl: begin
                    if (ctrl_start) begin
                      busy_q    <= 1'b1;
                      expaddr_q <= 1'b0;
                      idx_q     <= '0;
                      bytes_q   <= '0;
                      raw_q     <= raw_q & ~((32'd1 << IrqEnd) | (32'd1 << IrqFail) |
                                             (32'd1 << IrqNack));
                    end
                  end
                  OffFifoCf: begin
                    if (in_data_i.write_value[12]) begin
                      rx_head_q <= '0;
                      rx_cnt_q  <= '0;
                    end
                    if (in_data_i.write_value[13]) begin
                      tx_head_q <= '0;
                      tx_cnt_q  <= '0;
                    end
                  end
                  OffData: begin
                    if (tx_full) begin
                      raw_q <= raw_q | (32'd1 << IrqTxOvf);
                    end else begin
                      tx_cnt_q <= tx_cnt_q + 1'b1;
                    end
                  end
                  OffIrqClr: raw_q <= raw_q & ~in_data_i.write_value;
                  OffIrqEn:  en_q  <= in_data_i.write_value;
                  default: ;
                endcase
              end
              ActRead: state_q <= S_REG_RD;
              ActEvent: begin
                if (busy_q) begin
                  case (in_data_i.bus_event)
                    EvStart: begin
                      after_q <= AD_RUN;
                      state_q <= S_CD_RD;
                    end
                    EvAck, EvNack, EvByte: begin
                      if (in_data_i.bus_event == EvNack && ackchk_q) begin
                        raw_q     <= raw_q | (32'd1 << IrqNack);
                        fin_bit_q <= IrqNack;
                        fin_rel_q <= 1'b1;
                        state_q   <= S_FIN_RD;
                      end else begin
                        if (in_data_i.bus_event == EvNack) begin
                          raw_q <= raw_q | (32'd1 << IrqNack);
                        end
                        if (in_data_i.bus_event == EvByte) begin
                          if (rx_full) begin
                            raw_q <= raw_q | (32'd1 << IrqRxOvf);
                          end else begin
                            rx_cnt_q <= rx_cnt_q + 1'b1;
                          end
                        end
                        if (bytes_q == 8'd0) begin
                          state_q <= S_RUN_RD;
                        end else begin
                          bytes_q <= bytes_dec;
                          if (bytes_dec == 8'd0) begin
                            after_q <= AD_RUN;
                            state_q <= S_CD_RD;
                          end else if (in_data_i.bus_event == EvByte) begin
                            state_q <= S_ACK_RD;
                          end else begin
                            state_q <= S_TX_RD;
                          end
                        end
                      end
                    end
                    EvIdle: begin
                      after_q <= AD_FIN_FAIL;
                      state_q <= S_CD_RD;
                    end
                    default: state_q <= S_OUT;
                  endcase
                end else begin
                  state_q <= S_OUT;
                end
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_REG_RD: begin
          unique case (off_q)
            OffStatus: res_q.read_data <= (32'(busbusy_q) << 4) | (32'(rx_cnt_q) << 8) |
                                          (32'(tx_cnt_q) << 18);
            OffData: begin
              if (rx_cnt_q == '0) begin
                res_q.read_data <= '0;
                raw_q           <= raw_q | (32'd1 << IrqRxUnf);
              end else begin
                res_q.read_data <= 32'(rx_rdata_q);
                rx_head_q       <= rx_head_q + 1'b1;
                rx_cnt_q        <= rx_cnt_q - 1'b1;
              end
            end
            OffRawIrq: res_q.read_data <= raw_q;
            OffIrqSt:  res_q.read_data <= raw_q & en_q;
            default:   res_q.read_data <= rf_word;
          endcase
          state_q <= S_OUT;
        end
        S_CD_RD: state_q <= S_CD_WR;
        S_CD_WR: begin
          idx_q   <= idx_q + 1'b1;
          bytes_q <= '0;
          unique case (after_q)
            AD_RUN: state_q <= S_RUN_RD;
            AD_FIN_FAIL: begin
              fin_bit_q <= IrqFail;
              fin_rel_q <= 1'b1;
              state_q   <= S_FIN_RD;
            end
            default: begin
              fin_bit_q <= IrqEnd;
              fin_rel_q <= 1'b0;
              state_q   <= S_FIN_RD;
            end
          endcase
        end
        S_RUN_RD: begin
          if (idx_q < slots) begin
            state_q <= S_RUN_EX;
          end else begin
            fin_bit_q <= IrqFail;
            fin_rel_q <= 1'b1;
            state_q   <= S_FIN_RD;
          end
        end
        S_RUN_EX: begin
          bytes_q  <= rf_word[7:0];
          ackchk_q <= rf_word[8];
          if (opc == op_rs) begin
            busbusy_q    <= 1'b1;
            expaddr_q    <= 1'b1;
            res_q.bus_op <= OpStart;
            state_q      <= S_OUT;
          end else if (opc == CmdWrite || opc == op_rd) begin
            if (rf_word[7:0] == 8'd0) begin
              after_q <= AD_RUN;
              state_q <= S_CD_WR;
            end else if (opc == CmdWrite) begin
              state_q <= S_TX_RD;
            end else begin
              res_q.bus_op        <= OpRead;
              res_q.read_send_ack <= !rf_word[10];
              state_q             <= S_OUT;
            end
          end else if (opc == op_sp) begin
            res_q.bus_op <= OpStop;
            state_q      <= S_OUT;
          end else if (opc == CmdEnd) begin
            after_q <= AD_FIN_END;
            state_q <= S_CD_WR;
          end else begin
            fin_bit_q <= IrqFail;
            fin_rel_q <= 1'b1;
            state_q   <= S_FIN_RD;
          end
        end
        S_FIN_RD: state_q <= S_FIN_WR;
        S_FIN_WR: begin
          busy_q <= 1'b0;
          if (fin_rel_q) begin
            busbusy_q <= 1'b0;
          end
          raw_q   <= raw_q | (32'd1 << fin_bit_q);
          state_q <= S_OUT;
        end
        S_ACK_RD: state_q <= S_ACK_EX;
        S_ACK_EX: begin
          res_q.bus_op        <= OpRead;
          res_q.read_send_ack <= !rf_word[10];
          state_q             <= S_OUT;
        end
        S_TX_RD: begin
          if (tx_cnt_q == '0) begin
            fin_bit_q <= IrqTxEmp;
            fin_rel_q <= 1'b1;
            state_q   <= S_FIN_RD;
          end else begin
            state_q <= S_TX_EX;
          end
        end
        S_TX_EX: begin
          tx_head_q            <= tx_head_q + 1'b1;
          tx_cnt_q             <= tx_cnt_q - 1'b1;
          res_q.bus_op         <= OpWrite;
          res_q.bus_byte       <= tx_rdata_q;
          res_q.bus_is_address <= expaddr_q;
          if (expaddr_q) begin
            write_q             <= !tx_rdata_q[0];
            expaddr_q           <= 1'b0;
            res_q.bus_dir_write <= !tx_rdata_q[0];
          end else begin
            res_q.bus_dir_write <= write_q;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_q || !out_stall_i) begin
            out_q     <= res_fin;
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_i2c_command_list_master_core.sv
module tb_i2c_command_list_master_core;
  timeunit 1ns;
  timeprecision 1ps;

  import i2c_clm_pkg::*;

  localparam logic [2:0] LegRestart = 3'd0;
  localparam logic [2:0] LegRead    = 3'd2;
  localparam logic [2:0] LegStop    = 3'd3;
  localparam logic [2:0] ModRestart = 3'd6;
  localparam logic [2:0] ModRead    = 3'd3;
  localparam logic [2:0] ModStop    = 3'd2;
  localparam logic [1:0] ActNop     = 2'd3;
  localparam logic [2:0] EvOther    = 3'd5;
  localparam int unsigned PhaseItems = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  i2c_command_list_master_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow state of the master
  logic [31:0] shadow_regs[RegWords];
  logic [7:0]  tx_bytes[$];
  logic [7:0]  rx_bytes[$];
  logic [31:0] raw_irq;
  logic [31:0] irq_en;
  logic [4:0]  slot_idx;
  logic [7:0]  bytes_left;
  bit          f_busy, f_busbusy, f_expaddr, f_ackchk, f_master, f_wdir;
  bit          modern;
  out_item_t   step_res;

  in_item_t    stim_q[$];
  out_item_t   expected_q[$];
  int unsigned errors, n_items, n_results, n_bus_cmds;
  bit          in_taken;
  int unsigned in_gap, stall_len;

  function automatic int slot_word();
    return int'(CmdBase >> 2) + int'(slot_idx);
  endfunction

  function automatic void end_txn(logic [31:0] mask, bit release_bus);
    f_busy = 1'b0;
    if (release_bus) f_busbusy = 1'b0;
    shadow_regs[1][5] = 1'b0;
    raw_irq |= mask;
  endfunction

  function automatic void slot_done();
    shadow_regs[slot_word()] |= DoneBit;
    slot_idx = slot_idx + 5'd1;
    bytes_left = 8'd0;
  endfunction

  function automatic void send_byte();
    logic [7:0] b;
    bit         is_addr;
    if (tx_bytes.size() == 0) begin
      end_txn(32'd1 << IrqTxEmp, 1'b1);
      return;
    end
    b = tx_bytes[0];
    tx_bytes.delete(0);
    is_addr = f_expaddr;
    if (is_addr) begin
      f_wdir = ~b[0];
      f_expaddr = 1'b0;
    end
    step_res.bus_op = OpWrite;
    step_res.bus_byte = b;
    step_res.bus_is_address = is_addr;
    step_res.bus_dir_write = f_wdir;
  endfunction

  function automatic void read_byte();
    step_res.bus_op = OpRead;
    step_res.read_send_ack = ~shadow_regs[slot_word()][10];
  endfunction

  function automatic void walk_slots();
    logic [31:0] cmd;
    logic [2:0]  opc, op_rs, op_rd, op_sp;
    bit          going;
    going = 1'b1;
    op_rs = modern ? ModRestart : LegRestart;
    op_rd = modern ? ModRead : LegRead;
    op_sp = modern ? ModStop : LegStop;
    while (going && f_busy && int'(slot_idx) < (modern ? 8 : int'(MaxCommands))) begin
      cmd = shadow_regs[slot_word()];
      opc = cmd[13:11];
      bytes_left = cmd[7:0];
      f_ackchk = cmd[8];
      going = 1'b0;
      if (opc == op_rs) begin
        f_busbusy = 1'b1;
        f_expaddr = 1'b1;
        step_res.bus_op = OpStart;
      end else if (opc == CmdWrite || opc == op_rd) begin
        if (bytes_left == 0) begin
          slot_done();
          going = 1'b1;
        end else if (opc == CmdWrite) begin
          send_byte();
        end else begin
          read_byte();
        end
      end else if (opc == op_sp) begin
        step_res.bus_op = OpStop;
      end else if (opc == CmdEnd) begin
        slot_done();
        end_txn(32'd1 << IrqEnd, 1'b0);
      end else begin
        end_txn(32'd1 << IrqFail, 1'b1);
      end
    end
    if (going) end_txn(32'd1 << IrqFail, 1'b1);
  endfunction

  function automatic bit count_byte(bit reading);
    if (bytes_left != 0) begin
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 0) begin
        slot_done();
      end else begin
        if (reading) read_byte();
        else send_byte();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void take_event(logic [2:0] ev, logic [7:0] rxb);
    if (!f_busy) return;
    case (ev)
      EvStart: slot_done();
      EvAck: begin
        if (count_byte(1'b0)) return;
      end
      EvNack: begin
        raw_irq[IrqNack] = 1'b1;
        if (f_ackchk) begin
          end_txn(32'd1 << IrqNack, 1'b1);
          return;
        end
        if (count_byte(1'b0)) return;
      end
      EvByte: begin
        if (rx_bytes.size() < FifoDepth) rx_bytes.insert(rx_bytes.size(), rxb);
        else raw_irq[IrqRxOvf] = 1'b1;
        if (count_byte(1'b1)) return;
      end
      EvIdle: begin
        slot_done();
        end_txn(32'd1 << IrqFail, 1'b1);
        return;
      end
      default: return;
    endcase
    walk_slots();
  endfunction

  function automatic void reg_store(logic [7:0] off, logic [31:0] v);
    shadow_regs[off[7:2]] = v;
    case (off)
      OffCtrl: begin
        f_master = v[4];
        if (v[5] && !f_busy && f_master) begin
          f_busy = 1'b1;
          f_expaddr = 1'b0;
          slot_idx = 5'd0;
          bytes_left = 8'd0;
          raw_irq[IrqEnd] = 1'b0;
          raw_irq[IrqFail] = 1'b0;
          raw_irq[IrqNack] = 1'b0;
          walk_slots();
        end
      end
      OffFifoCf: begin
        if (v[12]) rx_bytes.delete();
        if (v[13]) tx_bytes.delete();
      end
      OffData: begin
        if (tx_bytes.size() < FifoDepth) tx_bytes.insert(tx_bytes.size(), v[7:0]);
        else raw_irq[IrqTxOvf] = 1'b1;
      end
      OffIrqClr: raw_irq &= ~v;
      OffIrqEn:  irq_en = v;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_fetch(logic [7:0] off);
    logic [31:0] v;
    v = shadow_regs[off[7:2]];
    case (off)
      OffStatus: v = (32'(f_busbusy) << 4) | (32'(rx_bytes.size()) << 8)
                     | (32'(tx_bytes.size()) << 18);
      OffData: begin
        if (rx_bytes.size() == 0) begin
          v = 32'd0;
          raw_irq[IrqRxUnf] = 1'b1;
        end else begin
          v = 32'(rx_bytes[0]);
          rx_bytes.delete(0);
        end
      end
      OffRawIrq: v = raw_irq;
      OffIrqSt:  v = raw_irq & irq_en;
      default: ;
    endcase
    return v;
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    step_res = '0;
    case (it.action)
      ActWrite: reg_store(it.reg_offset, it.write_value);
      ActRead:  step_res.read_data = reg_fetch(it.reg_offset);
      ActEvent: take_event(it.bus_event, it.rx_byte);
      default: ;
    endcase
    step_res.irq = |(raw_irq & irq_en);
    step_res.busy_res = f_busy;
    return step_res;
  endfunction

  // stimulus builders
  function automatic void add(logic [1:0] act, logic [7:0] off, logic [31:0] val,
                              logic [2:0] ev, logic [7:0] rxb);
    in_item_t it;
    it.action = act;
    it.reg_offset = off;
    it.write_value = val;
    it.bus_event = ev;
    it.rx_byte = rxb;
    stim_q.insert(stim_q.size(), it);
  endfunction

  function automatic void add_wr(logic [7:0] off, logic [31:0] val);
    add(ActWrite, off, val, 3'($urandom_range(0, 7)), 8'($urandom()));
  endfunction

  function automatic void add_rd(logic [7:0] off);
    add(ActRead, off, $urandom(), 3'($urandom_range(0, 7)), 8'($urandom()));
  endfunction

  function automatic void add_ev(logic [2:0] ev);
    add(ActEvent, 8'($urandom()), $urandom(), ev, 8'($urandom()));
  endfunction

  function automatic void add_noise();
    add(2'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
        3'($urandom_range(0, 7)), 8'($urandom()));
  endfunction

  function automatic void add_txn(bit mod);
    int unsigned ncmd, ntx, nev, r, cnt;
    logic [2:0]  opc;
    logic [31:0] cmd, hi;
    add_wr(OffFifoCf, 32'h0000_3000);
    if ($urandom_range(0, 3) == 0)
      add_wr(OffIrqEn, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom());
    ncmd = $urandom_range(1, 6);
    for (int i = 0; i < ncmd; i++) begin
      r = $urandom_range(0, 19);
      if (i == 0 || r < 4) opc = mod ? ModRestart : LegRestart;
      else if (r < 9) opc = CmdWrite;
      else if (r < 14) opc = mod ? ModRead : LegRead;
      else if (r < 16) opc = mod ? ModStop : LegStop;
      else if (r < 18) opc = CmdEnd;
      else opc = 3'($urandom_range(0, 7));
      r = $urandom_range(0, 19);
      cnt = r < 16 ? $urandom_range(1, 4) : (r < 18 ? 0 : $urandom_range(0, 255));
      hi = $urandom();
      cmd = {hi[31:14], opc, hi[10:8], 8'(cnt)};
      add_wr(8'(CmdBase + 4 * i), cmd);
    end
    ntx = $urandom_range(0, 19) == 0 ? 36 : $urandom_range(0, 10);
    for (int i = 0; i < ntx; i++) add_wr(OffData, $urandom());
    add_wr(OffCtrl, $urandom_range(0, 9) == 0 ? 32'h20 : (($urandom() & ~32'h30) | 32'h30));
    nev = $urandom_range(0, 24) == 0 ? 45 : $urandom_range(2, 14);
    for (int i = 0; i < nev; i++) begin
      r = $urandom_range(0, 19);
      if (r < 8) add_ev(EvAck);
      else if (r < 14) add_ev(EvByte);
      else if (r < 16) add_ev(EvStart);
      else if (r < 18) add_ev(EvNack);
      else if (r < 19) add_rd($urandom_range(0, 1) ? OffStatus : OffData);
      else add_ev($urandom_range(0, 1) ? EvIdle : 3'($urandom_range(EvOther, 7)));
    end
    r = $urandom_range(0, 3);
    if (r == 0) add_rd(OffRawIrq);
    if (r == 1) add_wr(OffIrqClr, $urandom());
    if (r == 2) add_rd(OffIrqSt);
    for (int i = $urandom_range(0, 3); i > 0; i--) add_rd(OffData);
  endfunction

  function automatic void add_directed();
    add_rd(OffStatus);
    add_rd(OffData);
    add_rd(OffRawIrq);
    add_wr(OffIrqEn, 32'hFFFF_FFFF);
    add_rd(OffIrqSt);
    add_wr(8'hFF, 32'hFFFF_FFFF);
    add_rd(8'hFF);
    add_wr(8'h00, 32'h0000_0000);
    add_rd(8'h00);
    add_wr(8'h05, 32'hA5A5_5A5A);
    add_rd(8'h05);
    add_ev(EvAck);
    add(ActNop, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);
    add_wr(OffCtrl, 32'h20);
    add_wr(CmdBase, {18'd0, LegRestart, 3'b000, 8'd0});
    add_wr(8'(CmdBase + 4), {18'd0, CmdWrite, 3'b001, 8'd1});
    add_wr(8'(CmdBase + 8), {18'd0, CmdEnd, 11'd0});
    add_wr(OffData, 32'h0000_00A1);
    add_wr(OffCtrl, 32'h30);
    add_wr(OffCtrl, 32'h30);
    add_ev(EvStart);
    add_ev(EvNack);
    add_rd(OffRawIrq);
    add_wr(OffIrqClr, 32'hFFFF_FFFF);
    add_rd(OffStatus);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_q.insert(expected_q.size(), predict_step(in_data));
      n_items++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        in_data <= stim_q[0];
        stim_q.delete(0);
        in_valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (stall_len > 0) begin
      stall_len--;
      out_stall <= 1'b1;
    end else begin
      stall_len = pick_gap();
      out_stall <= 1'b0;
    end
  end

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_data.bus_op != OpNone) n_bus_cmds++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, out_data);
        errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        cmp_field("read_data", e.read_data, out_data.read_data);
        cmp_field("irq", 32'(e.irq), 32'(out_data.irq));
        cmp_field("bus_op", 32'(e.bus_op), 32'(out_data.bus_op));
        cmp_field("bus_byte", 32'(e.bus_byte), 32'(out_data.bus_byte));
        cmp_field("bus_is_address", 32'(e.bus_is_address), 32'(out_data.bus_is_address));
        cmp_field("bus_dir_write", 32'(e.bus_dir_write), 32'(out_data.bus_dir_write));
        cmp_field("read_send_ack", 32'(e.read_send_ack), 32'(out_data.read_send_ack));
        cmp_field("busy_res", 32'(e.busy_res), 32'(out_data.busy_res));
      end
    end
  end

  task automatic write_variant(bit v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    modern = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (stim_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    bit variants[4];
    int unsigned target;
    variants = '{1'b0, 1'b1, 1'b0, 1'b1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    stall_len = 0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_bus_cmds = 0;
    for (int i = 0; i < RegWords; i++) shadow_regs[i] = '0;
    raw_irq = '0;
    irq_en = '0;
    slot_idx = '0;
    bytes_left = '0;
    {f_busy, f_busbusy, f_expaddr, f_ackchk, f_master, f_wdir} = '0;
    modern = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < 4; p++) begin
      write_variant(variants[p]);
      if (p == 0) add_directed();
      target = stim_q.size() + PhaseItems;
      while (stim_q.size() < target) begin
        if ($urandom_range(0, 9) < 8) add_txn(variants[p]);
        else add_noise();
      end
      drain();
    end
    $display("tb: %0d items in 4 variant phases, %0d results, %0d bus commands",
             n_items, n_results, n_bus_cmds);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
